@@ rtl/core/urb_pkg.sv @@
`default_nettype none

package urb_pkg;

   localparam int unsigned TRIG_W      = 8;
   localparam int unsigned PERIOD_W    = 16;
   localparam int unsigned DIST_W      = 11;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned BAR_W       = 8;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [TRIG_W-1:0]   TRIGGER_TICKS_RESET = 8'd10;
   localparam logic [PERIOD_W-1:0] PERIOD_TICKS_RESET  = 16'd55296;

   localparam logic [DIST_W-1:0] DIST_MAX  = 11'd2047;
   localparam logic [DIST_W-1:0] BAR_LIMIT = 11'd40;

   // floor(x / 10) = (x * 6554) >> 16 for x below 2048
   localparam logic [12:0] DIV10_MUL_WIDE = 13'd6554;
   // floor(x / 10) = (x * 205) >> 11 for x below 1029
   localparam logic [7:0]  DIV10_MUL_NARROW = 8'd205;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRIGGER_TICKS = 2'd0,
      CSR_PERIOD_TICKS  = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic trig;
      logic done;
   } tick_ctl_type;

   function automatic logic [BAR_W-1:0] bar_fill(input logic [5:0] cm);
      logic [BAR_W-1:0] pattern;
      case (cm) inside
         [6'd0:6'd4]:   pattern = 8'h01;
         [6'd5:6'd9]:   pattern = 8'h03;
         [6'd10:6'd14]: pattern = 8'h07;
         [6'd15:6'd19]: pattern = 8'h0F;
         [6'd20:6'd24]: pattern = 8'h1F;
         [6'd25:6'd29]: pattern = 8'h3F;
         [6'd30:6'd34]: pattern = 8'h7F;
         [6'd35:6'd39]: pattern = 8'hFF;
         default:       pattern = 8'hFF;
      endcase
      return pattern;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/urb_range.sv @@
`default_nettype none

module urb_range #(
   parameter int unsigned TICKS_PER_CM = 58,
   parameter int unsigned COUNT_WIDTH  = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  urb_pkg::tick_ctl_type          in_ctl,
   input  logic [COUNT_WIDTH-1:0]         in_width,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic                           out_trigger,
   output logic [urb_pkg::DIST_W-1:0]     out_distance,
   output logic [urb_pkg::DIGIT_W-1:0]    out_tens,
   output logic [urb_pkg::DIGIT_W-1:0]    out_ones,
   output logic [urb_pkg::BAR_W-1:0]      out_bar,
   output logic                           out_done
);

   localparam int unsigned DIV_SHIFT = COUNT_WIDTH + $clog2(TICKS_PER_CM);
   localparam int unsigned RECIP_W   = COUNT_WIDTH + 2;
   localparam int unsigned PROD_W    = COUNT_WIDTH + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
      ((64'd1 << DIV_SHIFT) + 64'(TICKS_PER_CM) - 64'd1) / 64'(TICKS_PER_CM));

   logic                            s2_en;
   logic                            s3_en;
   logic                            s4_en;

   logic                            s2_valid_ff;
   urb_pkg::tick_ctl_type           s2_ctl_ff;
   logic [PROD_W-1:0]               s2_prod_ff;
   logic [PROD_W-1:0]               s2_prod_in;

   logic                            s3_valid_ff;
   urb_pkg::tick_ctl_type           s3_ctl_ff;
   logic [urb_pkg::DIST_W-1:0]      s3_dist_ff;
   logic [7:0]                      s3_decade_ff;
   logic [PROD_W-1:0]               quot_wide;
   logic [urb_pkg::DIST_W-1:0]      s3_dist_in;
   logic [23:0]                     decade_prod;

   logic [15:0]                     hund_prod;
   logic [7:0]                      hund_x10;
   logic [7:0]                      tens_full;
   logic [urb_pkg::DIST_W-1:0]      decade_x10;
   logic [urb_pkg::DIST_W-1:0]      ones_full;

   logic                            out_valid_ff;
   logic                            out_trigger_ff;
   logic                            out_done_ff;
   logic [urb_pkg::DIST_W-1:0]      dist_ff;
   logic [urb_pkg::DIGIT_W-1:0]     tens_ff;
   logic [urb_pkg::DIGIT_W-1:0]     ones_ff;
   logic [urb_pkg::BAR_W-1:0]       bar_ff;

   assign s4_en    = !out_valid_ff || out_ready;
   assign s3_en    = !s3_valid_ff || s4_en;
   assign s2_en    = !s2_valid_ff || s3_en;
   assign in_ready = s2_en;

   // width / TICKS_PER_CM by reciprocal
   assign s2_prod_in = PROD_W'(in_width) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_ctl_ff  <= in_ctl;
         s2_prod_ff <= s2_prod_in;
      end
   end

   assign quot_wide  = s2_prod_ff >> DIV_SHIFT;
   assign s3_dist_in = (quot_wide > PROD_W'(urb_pkg::DIST_MAX)) ?
                       urb_pkg::DIST_MAX : quot_wide[urb_pkg::DIST_W-1:0];
   assign decade_prod = 24'(s3_dist_in) * 24'(urb_pkg::DIV10_MUL_WIDE);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_ctl_ff    <= s2_ctl_ff;
         s3_dist_ff   <= s3_dist_in;
         s3_decade_ff <= decade_prod[23:16];
      end
   end

   assign hund_prod  = 16'(s3_decade_ff) * 16'(urb_pkg::DIV10_MUL_NARROW);
   assign hund_x10   = 8'(hund_prod[15:11]) * 8'd10;
   assign tens_full  = s3_decade_ff - hund_x10;
   assign decade_x10 = urb_pkg::DIST_W'(s3_decade_ff) * 11'd10;
   assign ones_full  = s3_dist_ff - decade_x10;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         out_trigger_ff <= 1'b0;
         out_done_ff    <= 1'b0;
         dist_ff        <= '0;
         tens_ff        <= '0;
         ones_ff        <= '0;
         bar_ff         <= '0;
      end else if (s4_en) begin
         out_valid_ff   <= s3_valid_ff;
         out_trigger_ff <= s3_ctl_ff.trig;
         out_done_ff    <= s3_ctl_ff.done;
         if (s3_valid_ff && s3_ctl_ff.done) begin
            dist_ff <= s3_dist_ff;
            tens_ff <= tens_full[urb_pkg::DIGIT_W-1:0];
            ones_ff <= ones_full[urb_pkg::DIGIT_W-1:0];
            if (s3_dist_ff < urb_pkg::BAR_LIMIT) begin
               bar_ff <= urb_pkg::bar_fill(s3_dist_ff[5:0]);
            end
         end
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_trigger  = out_trigger_ff;
   assign out_done     = out_done_ff;
   assign out_distance = dist_ff;
   assign out_tens     = tens_ff;
   assign out_ones     = ones_ff;
   assign out_bar      = bar_ff;

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_tens <= 4'd9) && (out_ones <= 4'd9))
      else $error("digit out of range");

   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> ((out_bar + 8'd1) & out_bar) == 8'd0)
      else $error("bar is not a thermometer code");

   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> s3_decade_ff <= 8'd204)
      else $error("decade quotient out of range");
`endif

endmodule

`default_nettype wire

@@ rtl/core/ultrasonic_ranger_bar.sv @@
`default_nettype none
// Datapath: each accepted echo word passes the input, divide, digit and result
// registers in order. Throughput: one word per cycle unless rsp_ready stalls the
// output; these registers each hold one word and advance independently.
// Reset clears the period counter, echo tracking, width counter, distance,
// digits and bar, and loads trigger_ticks = 10 and period_ticks = 55296.

module ultrasonic_ranger_bar #(
   parameter int unsigned TICKS_PER_CM = 58,
   parameter int unsigned COUNT_WIDTH  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_echo_level,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_trigger_out,
   output logic [urb_pkg::DIST_W-1:0]          rsp_distance_cm,
   output logic [urb_pkg::DIGIT_W-1:0]         rsp_tens_digit,
   output logic [urb_pkg::DIGIT_W-1:0]         rsp_ones_digit,
   output logic [urb_pkg::BAR_W-1:0]           rsp_bar_pattern,
   output logic                                rsp_measure_done,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [urb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [urb_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [urb_pkg::TRIG_W-1:0]     trigger_ticks_ff;
   logic [urb_pkg::PERIOD_W-1:0]   period_ticks_ff;

   logic [urb_pkg::PERIOD_W-1:0]   period_count_ff;
   logic [urb_pkg::PERIOD_W-1:0]   period_count_in;
   logic [urb_pkg::PERIOD_W:0]     count_inc;
   logic                           echo_prev_ff;
   logic                           echo_active_ff;
   logic                           echo_active_in;
   logic [COUNT_WIDTH-1:0]         width_count_ff;
   logic [COUNT_WIDTH-1:0]         width_count_in;

   logic                           req_fire;
   logic                           s1_en;
   logic                           range_ready;
   logic                           s1_valid_ff;
   urb_pkg::tick_ctl_type          s1_ctl_ff;
   urb_pkg::tick_ctl_type          s1_ctl_in;
   logic [COUNT_WIDTH-1:0]         s1_width_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ticks_ff <= urb_pkg::TRIGGER_TICKS_RESET;
         period_ticks_ff  <= urb_pkg::PERIOD_TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (urb_pkg::csr_index_type'(csr_index))
            urb_pkg::CSR_TRIGGER_TICKS: begin
               trigger_ticks_ff <= csr_wdata[urb_pkg::TRIG_W-1:0];
            end
            urb_pkg::CSR_PERIOD_TICKS: begin
               period_ticks_ff <= csr_wdata[urb_pkg::PERIOD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign s1_en     = !s1_valid_ff || range_ready;
   assign req_ready = s1_en;
   assign req_fire  = req_valid && req_ready;

   assign count_inc       = {1'b0, period_count_ff} + 17'd1;
   assign period_count_in = (count_inc >= {1'b0, period_ticks_ff}) ?
                            '0 : count_inc[urb_pkg::PERIOD_W-1:0];

   always_comb begin
      width_count_in = width_count_ff;
      echo_active_in = echo_active_ff;
      s1_ctl_in.trig = (period_count_ff < urb_pkg::PERIOD_W'(trigger_ticks_ff));
      s1_ctl_in.done = 1'b0;
      if (req_echo_level && !echo_prev_ff) begin
         width_count_in = COUNT_WIDTH'(1);
         echo_active_in = 1'b1;
      end else if (req_echo_level && echo_active_ff) begin
         if (width_count_ff != '1) begin
            width_count_in = width_count_ff + COUNT_WIDTH'(1);
         end
      end else if (!req_echo_level && echo_prev_ff && echo_active_ff) begin
         echo_active_in = 1'b0;
         s1_ctl_in.done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_count_ff <= '0;
         echo_prev_ff    <= 1'b0;
         echo_active_ff  <= 1'b0;
         width_count_ff  <= '0;
      end else if (req_fire) begin
         period_count_ff <= period_count_in;
         echo_prev_ff    <= req_echo_level;
         echo_active_ff  <= echo_active_in;
         width_count_ff  <= width_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_ctl_ff   <= s1_ctl_in;
         s1_width_ff <= width_count_ff;
      end
   end

   urb_range #(
      .TICKS_PER_CM (TICKS_PER_CM),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_range (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s1_valid_ff),
      .in_ready     (range_ready),
      .in_ctl       (s1_ctl_ff),
      .in_width     (s1_width_ff),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_trigger  (rsp_trigger_out),
      .out_distance (rsp_distance_cm),
      .out_tens     (rsp_tens_digit),
      .out_ones     (rsp_ones_digit),
      .out_bar      (rsp_bar_pattern),
      .out_done     (rsp_measure_done)
   );

`ifndef NO_ASSERTIONS
   assert property (@(posedge clock) disable iff (reset)
      echo_active_ff |-> echo_prev_ff)
      else $error("pulse tracked while echo low");

   assert property (@(posedge clock) disable iff (reset)
      echo_active_ff |-> width_count_ff != '0)
      else $error("active pulse with empty width");

   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");
`endif

endmodule

`default_nettype wire
